>>> rtl/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg: shared types and constants of the elevator call scheduler
// Field widths, event codes, travel direction codes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ecs_pkg;

   // Widths of the transaction fields.
   localparam int OP_W    = 2;
   localparam int FLOOR_W = 5;

   // Event codes carried in the op field.
   localparam logic [OP_W-1:0] OP_CALL   = 2'd0;
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
   localparam logic [OP_W-1:0] OP_PASS   = 2'd2;

   // Travel direction of the car.
   typedef enum logic [1:0] {
      MOTION_STAY = 2'd0,
      MOTION_UP   = 2'd1,
      MOTION_DOWN = 2'd2
   } motion_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;   // capture the accepted request transaction
      logic exec;        // apply the event to the car state
      logic pick_target; // choose a new far target
      logic emit;        // load the response register and set the heading
      logic go_idle;     // no stop left, clear the busy flag
   } ecs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic            item_ok;   // floor in range and op known
      logic [OP_W-1:0] op;        // op of the captured transaction
      logic            busy;      // car has work
      logic            at_target; // captured floor equals the far target
      logic            have_stop; // a stop is to be reported
   } ecs_status_type;

endpackage

`default_nettype wire

>>> rtl/ecs_if.sv
// ----------------------------------------------------------------------------
// ecs_if: request and response channels of the elevator call scheduler
// Valid/ready channels; a transaction moves when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecs_req_if
   import ecs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [FLOOR_W-1:0] floor;

   modport source (output valid, output op, output floor, input ready);
   modport sink   (input valid, input op, input floor, output ready);
endinterface

interface ecs_rsp_if
   import ecs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FLOOR_W-1:0] stop_floor;
   logic               heading_down;

   modport source (output valid, output stop_floor, output heading_down, input ready);
   modport sink   (input valid, input stop_floor, input heading_down, output ready);
endinterface

`default_nettype wire

>>> rtl/ecs_ctrl.sv
// ----------------------------------------------------------------------------
// ecs_ctrl: sequencing controller of the elevator call scheduler
// Steps one request transaction through execute, target selection and stop
// scan, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_ctrl
   import ecs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire ecs_status_type status,
   output ecs_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TARGET,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The response register can take a new value when empty or being drained.
   // No request transaction is taken while reset is held.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   // Commands and next state.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = status.item_ok;
            state_in = ST_IDLE;
            if (status.item_ok) begin
               case (status.op)
                  OP_CALL: state_in = ST_SCAN;
                  OP_ARRIVE: begin
                     if (status.busy) begin
                        state_in = status.at_target ? ST_TARGET : ST_SCAN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TARGET: begin
            cmd.pick_target = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            if (!status.have_stop) begin
               cmd.go_idle = 1'b1;
               state_in    = ST_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ecs_datapath.sv
// ----------------------------------------------------------------------------
// ecs_datapath: car state and call bitmap of the elevator call scheduler
// Holds the car floor, far target, pending calls, busy flag and direction,
// and finds stops with masked first-set-bit searches over the bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_datapath
   import ecs_pkg::*;
#(
   parameter int FLOORS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [FLOOR_W-1:0] req_floor,
   input  wire ecs_cmd_type        cmd,
   output ecs_status_type          status,
   output logic [FLOOR_W-1:0]      rsp_stop_floor,
   output logic                    rsp_heading_down
);

   logic [OP_W-1:0]    op_ff;
   logic [FLOOR_W-1:0] floor_ff;
   logic [FLOOR_W-1:0] car_ff, car_in;
   logic [FLOOR_W-1:0] far_ff, far_in;
   logic [FLOORS-1:0]  pending_ff, pending_in;
   logic               busy_ff, busy_in;
   motion_type         motion_ff, motion_in;
   logic [FLOOR_W-1:0] stop_ff;
   logic               heading_ff;

   logic [FLOORS-1:0]  floor_bit;
   logic [FLOORS-1:0]  up_mask;
   logic [FLOORS-1:0]  down_mask;
   logic [FLOORS-1:0]  ahead_up;
   logic [FLOORS-1:0]  ahead_down;
   logic               scan_up;
   logic               stop_found;
   logic [FLOOR_W-1:0] nearest;
   logic [FLOOR_W-1:0] call_far;
   logic [FLOOR_W-1:0] far_base;
   logic               car_above;

   // Floor number of the lowest set bit; bit i stands for floor i+1.
   function automatic logic [FLOOR_W-1:0] lowest_floor(input logic [FLOORS-1:0] v);
      logic [FLOORS-1:0]  iso;
      logic [FLOOR_W-1:0] idx;
      iso = v & (~v + FLOORS'(1));
      idx = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (iso[i]) idx = idx | FLOOR_W'(i + 1);
      end
      return idx;
   endfunction

   // Floor number of the highest set bit, found on the reversed vector.
   function automatic logic [FLOOR_W-1:0] highest_floor(input logic [FLOORS-1:0] v);
      logic [FLOORS-1:0]  rev;
      logic [FLOORS-1:0]  iso;
      logic [FLOOR_W-1:0] idx;
      for (int i = 0; i < FLOORS; i++) begin
         rev[i] = v[FLOORS-1-i];
      end
      iso = rev & (~rev + FLOORS'(1));
      idx = '0;
      for (int j = 0; j < FLOORS; j++) begin
         if (iso[j]) idx = idx | FLOOR_W'(FLOORS - j);
      end
      return idx;
   endfunction

   // Per-floor decode of the event floor and of the car position.
   always_comb begin
      for (int i = 0; i < FLOORS; i++) begin
         floor_bit[i] = (int'(floor_ff) == i + 1);
         up_mask[i]   = (i + 1 >= int'(car_ff));
         down_mask[i] = (i + 1 <= int'(car_ff));
      end
   end

   // Nearest pending floor from the car toward the far target.
   assign scan_up    = (far_ff > car_ff);
   assign ahead_up   = pending_ff & up_mask;
   assign ahead_down = pending_ff & down_mask;
   assign stop_found = scan_up ? (|ahead_up) : (|ahead_down);
   assign nearest    = scan_up ? lowest_floor(ahead_up) : highest_floor(ahead_down);
   assign car_above  = (car_ff > far_ff);

   // A call sets the target when there is none and pushes it outward.
   always_comb begin
      far_base = (far_ff == '0) ? floor_ff : far_ff;
      call_far = far_base;
      if ((motion_ff == MOTION_UP && floor_ff > far_base) ||
          (motion_ff == MOTION_DOWN && floor_ff < far_base)) begin
         call_far = floor_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.item_ok   = (floor_ff != '0) && (int'(floor_ff) <= FLOORS) &&
                         (op_ff == OP_CALL || op_ff == OP_ARRIVE || op_ff == OP_PASS);
      status.op        = op_ff;
      status.busy      = busy_ff;
      status.at_target = (floor_ff == far_ff);
      status.have_stop = stop_found || (op_ff == OP_CALL);
   end

   // Next values of the car state.
   always_comb begin
      car_in     = car_ff;
      far_in     = far_ff;
      pending_in = pending_ff;
      busy_in    = busy_ff;
      motion_in  = motion_ff;
      if (cmd.exec) begin
         case (op_ff)
            OP_CALL: begin
               busy_in    = 1'b1;
               pending_in = pending_ff | floor_bit;
               far_in     = call_far;
            end
            OP_ARRIVE: begin
               if (busy_ff) begin
                  car_in     = floor_ff;
                  pending_in = pending_ff & ~floor_bit;
               end
            end
            OP_PASS: car_in = floor_ff;
            default: car_in = car_ff;
         endcase
      end
      // Going up the new target is the highest call, otherwise the lowest.
      if (cmd.pick_target) begin
         if (motion_ff == MOTION_UP) begin
            far_in = highest_floor(pending_ff);
         end else begin
            far_in = lowest_floor(pending_ff);
         end
      end
      if (cmd.emit) begin
         motion_in = car_above ? MOTION_DOWN : MOTION_UP;
      end
      if (cmd.go_idle) begin
         busy_in = 1'b0;
      end
   end

   // Car state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         car_ff     <= FLOOR_W'(1);
         far_ff     <= '0;
         pending_ff <= '0;
         busy_ff    <= 1'b0;
         motion_ff  <= MOTION_STAY;
      end else begin
         car_ff     <= car_in;
         far_ff     <= far_in;
         pending_ff <= pending_in;
         busy_ff    <= busy_in;
         motion_ff  <= motion_in;
      end
   end

   // Captured request and response payload.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= req_op;
         floor_ff <= req_floor;
      end
      if (cmd.emit) begin
         stop_ff    <= stop_found ? nearest : floor_ff;
         heading_ff <= car_above;
      end
   end

   assign rsp_stop_floor   = stop_ff;
   assign rsp_heading_down = heading_ff;

endmodule

`default_nettype wire

>>> rtl/elevator_call_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_call_scheduler: SCAN style elevator call scheduler
// Keeps pending floor calls and the car state, and answers call and arrival
// events with the next stop and travel direction.
// ----------------------------------------------------------------------------
//
//   Channel    Dir   Fields                        Transaction
//   req_chan   in    op[1:0], floor[4:0]           one car or call event
//   rsp_chan   out   stop_floor[4:0], heading_down zero or one per event
//
// A call, or an arrival away from the target, steps through execute and
// stop scan; an arrival at the far target adds a target selection step
// between them. Passed-floor and ignored events return to idle after execute.
// Synchronous reset returns the car to floor 1, idle, with no calls.
// A held response stalls the stop scan step until the response is taken;
// a new event is accepted while an earlier response still waits.
//
`default_nettype none

module elevator_call_scheduler
   import ecs_pkg::*;
#(
   parameter int FLOORS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   ecs_req_if.sink   req_chan,
   ecs_rsp_if.source rsp_chan
);

   ecs_cmd_type    cmd;
   ecs_status_type status;

   // Sequencing controller.
   ecs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Car state and stop search.
   ecs_datapath #(
      .FLOORS (FLOORS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_chan.op),
      .req_floor        (req_chan.floor),
      .cmd              (cmd),
      .status           (status),
      .rsp_stop_floor   (rsp_chan.stop_floor),
      .rsp_heading_down (rsp_chan.heading_down)
   );

endmodule

`default_nettype wire

>>> tb/sv/elevator_call_scheduler_tb.sv
// ----------------------------------------------------------------------------
// elevator_call_scheduler_tb: self-checking bench for the call scheduler
// Sends call, arrival and passed-floor events, mostly as believable car
// journeys that follow the stops the block hands out, plus stray events the
// block has to drop. A tracker class keeps its own copy of the car state and
// the call bitmap and checks each stop transaction in order.
// ----------------------------------------------------------------------------
module elevator_call_scheduler_tb
   import ecs_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLOORS = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_EVENTS = 1800;
   localparam int PHASE_EVENTS = 300;

   // The op code that no event uses; the block has to drop it.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // One stop transaction as the block should send it.
   typedef struct {
      logic [FLOOR_W-1:0] stop_floor;
      logic               heading_down;
   } stop_order_type;

   // Tracks the car and its calls, and holds the stops still to come.
   class stop_tracker;
      logic [FLOOR_W-1:0] car_floor;
      logic [FLOOR_W-1:0] far_target;
      logic [FLOORS-1:0]  calls;
      bit                 busy;
      motion_type         motion;
      int                 next_stop;
      int                 errors;
      stop_order_type     due_stops[$];

      function new();
         car_floor = FLOOR_W'(1);
         far_target = '0;
         calls = '0;
         busy = 0;
         motion = MOTION_STAY;
         next_stop = 0;
         errors = 0;
      endfunction

      // Nearest floor with a call, from the car toward the far target.
      function int nearest_call();
         int f;
         if (far_target > car_floor) begin
            for (f = car_floor; f <= FLOORS; f++)
               if (calls[f-1]) return f;
         end else begin
            for (f = car_floor; f >= 1; f--)
               if (calls[f-1]) return f;
         end
         return 0;
      endfunction

      // Going up the new target is the highest call, otherwise the lowest.
      function void choose_far_target();
         int f;
         if (motion == MOTION_UP) begin
            for (f = FLOORS; f >= 1; f--)
               if (calls[f-1]) begin
                  far_target = FLOOR_W'(f);
                  return;
               end
         end else begin
            for (f = 1; f <= FLOORS; f++)
               if (calls[f-1]) begin
                  far_target = FLOOR_W'(f);
                  return;
               end
         end
      endfunction

      // Sets the heading and queues the stop the block must report.
      function void send_to(int stop);
         stop_order_type order;
         motion = (car_floor > far_target) ? MOTION_DOWN : MOTION_UP;
         order.stop_floor = FLOOR_W'(stop);
         order.heading_down = (motion == MOTION_DOWN);
         due_stops.push_back(order);
         next_stop = stop;
      endfunction

      // Applies one accepted event transaction to the car state.
      function void note_event(logic [OP_W-1:0] op, logic [FLOOR_W-1:0] floor);
         int stop;
         if (floor < 1 || floor > FLOORS) return;
         case (op)
            OP_CALL: begin
               busy = 1;
               calls[floor-1] = 1'b1;
               if (far_target == 0) far_target = floor;
               if ((motion == MOTION_UP && floor > far_target) ||
                   (motion == MOTION_DOWN && floor < far_target))
                  far_target = floor;
               stop = nearest_call();
               if (stop == 0) stop = floor;
               send_to(stop);
            end
            OP_ARRIVE: begin
               if (!busy) return;
               car_floor = floor;
               calls[floor-1] = 1'b0;
               if (car_floor == far_target) begin
                  far_target = 0;
                  choose_far_target();
               end
               stop = nearest_call();
               if (stop == 0) begin
                  busy = 0;
                  next_stop = 0;
               end else begin
                  send_to(stop);
               end
            end
            OP_PASS: car_floor = floor;
            default: ;
         endcase
      endfunction

      // Compares one stop transaction with the oldest one due.
      function void check_stop(logic [FLOOR_W-1:0] stop_floor, logic heading_down);
         stop_order_type order;
         if (due_stops.size() == 0) begin
            errors++;
            $display("%0t: unexpected stop: expected none, actual floor %0d down %0b",
                     $time, stop_floor, heading_down);
            return;
         end
         order = due_stops.pop_front();
         if (stop_floor !== order.stop_floor) begin
            errors++;
            $display("%0t: stop_floor: expected %0d, actual %0d",
                     $time, order.stop_floor, stop_floor);
         end
         if (heading_down !== order.heading_down) begin
            errors++;
            $display("%0t: heading_down: expected %0b, actual %0b",
                     $time, order.heading_down, heading_down);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   send_steady;
   bit   take_steady;
   int   events;
   stop_tracker tracker;

   ecs_req_if req_chan();
   ecs_rsp_if rsp_chan();

   elevator_call_scheduler #(.FLOORS(FLOORS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Idle gap length: mostly none or short, now and then long.
   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Drives one event and waits until the block takes the transaction.
   task automatic send_event(logic [OP_W-1:0] op, logic [FLOOR_W-1:0] floor);
      int gap;
      gap = pick_gap(send_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.floor <= floor;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      tracker.note_event(op, floor);
   endtask

   // Holds the sender until every stop due has come back.
   task automatic drain_stops();
      req_chan.valid <= 1'b0;
      while (tracker.due_stops.size() != 0) @(posedge clock);
   endtask

   // Stray event the block must drop: unused op or floor out of range.
   task automatic send_stray();
      int r;
      r = $urandom_range(0, 2);
      if (r == 0)
         send_event(OP_UNUSED, FLOOR_W'($urandom_range(0, 31)));
      else if (r == 1)
         send_event(OP_W'($urandom_range(0, 3)), '0);
      else
         send_event(OP_W'($urandom_range(0, 3)),
                    FLOOR_W'($urandom_range(FLOORS + 1, 31)));
   endtask

   // Response side: ready with random stalls.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         int hold;
         hold = pick_gap(take_steady);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Each accepted stop transaction is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_stop(rsp_chan.stop_floor, rsp_chan.heading_down);
   end

   // Stimulus: directed journey first, then random journeys in phases.
   initial begin
      int r;
      tracker = new();
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_CALL;
      req_chan.floor <= '0;
      send_steady = 1'b1;
      take_steady = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: dropped events, far target extension, turnaround, going idle.
      send_event(OP_ARRIVE, 5);
      send_event(OP_CALL, 0);
      send_event(OP_CALL, 17);
      send_event(OP_UNUSED, 4);
      send_event(OP_PASS, 31);
      send_event(OP_CALL, 16);
      send_event(OP_CALL, 1);
      send_event(OP_PASS, 8);
      send_event(OP_CALL, 4);
      send_event(OP_ARRIVE, 16);
      send_event(OP_CALL, 15);
      send_event(OP_ARRIVE, 15);
      send_event(OP_ARRIVE, 0);
      send_event(OP_ARRIVE, 4);
      send_event(OP_ARRIVE, 1);
      send_event(OP_ARRIVE, 3);
      send_event(OP_CALL, 1);
      send_event(OP_ARRIVE, 1);
      send_event(OP_UNUSED, 31);
      send_event(OP_CALL, 2);
      send_event(OP_CALL, 16);
      send_event(OP_PASS, 9);
      send_event(OP_ARRIVE, 16);
      send_event(OP_ARRIVE, 2);
      drain_stops();

      // Random journeys: the car mostly travels to the stop it was given.
      send_steady = 1'b0;
      events = 0;
      while (events < RANDOM_EVENTS) begin
         if (events % PHASE_EVENTS == 0 && events != 0) begin
            drain_stops();
            repeat ($urandom_range(1, 8)) @(posedge clock);
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_stray();
            continue;
         end
         if (r < 33)
            send_event(OP_CALL, FLOOR_W'($urandom_range(1, FLOORS)));
         else if (r < 40)
            send_event(OP_PASS, FLOOR_W'($urandom_range(1, FLOORS)));
         else if (r < 45)
            send_event(OP_ARRIVE, FLOOR_W'($urandom_range(1, FLOORS)));
         else if (tracker.busy && tracker.next_stop != 0) begin
            if ($urandom_range(0, 2) == 0) begin
               send_event(OP_PASS, FLOOR_W'($urandom_range(tracker.car_floor,
                                                           tracker.next_stop)));
               events++;
            end
            send_event(OP_ARRIVE, FLOOR_W'(tracker.next_stop));
         end else
            send_event(OP_CALL, FLOOR_W'($urandom_range(1, FLOORS)));
         events++;
      end

      // Let the last stops come back, then allow the block to settle.
      drain_stops();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_stops.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #15_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ecs_pkg.sv
rtl/ecs_if.sv
rtl/ecs_ctrl.sv
rtl/ecs_datapath.sv
rtl/elevator_call_scheduler.sv
tb/sv/elevator_call_scheduler_tb.sv
